FILE: src/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and constants for the clock-sweep key-value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned SlotWidth  = 4;
  localparam int unsigned CountWidth = 3;

  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } csc_kind_e;

  typedef struct packed {
    csc_kind_e                     kind;
    logic signed [KeyWidth-1:0]    key;
    logic signed [ValueWidth-1:0]  new_value;
  } csc_req_t;

  typedef struct packed {
    logic                          hit;
    logic signed [ValueWidth-1:0]  read_value;
    logic [SlotWidth-1:0]          slot;
  } csc_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_SWEEP,
    ST_RESP
  } csc_state_e;

endpackage

`default_nettype wire

FILE: src/clock_sweep_cache.sv
// ----------------------------------------------------------------------------
// clock_sweep_cache
// Key-value cache with clock-sweep replacement, one slot visited per cycle.
// ----------------------------------------------------------------------------
// A hit at slot s returns once the scan has compared slot s, a get miss once
// every slot has been compared, and a put miss after that scan plus a sweep in
// which the hand visits v slots (1 to 7 * ENTRIES + 1).
// One item is in flight at a time; the single slot read port and the one
// count update per cycle set the pace. Reset (rst_ni low, asynchronous)
// clears all valid bits, usage counts and the hand, and sets max_usage to 5.
`default_nettype none

module clock_sweep_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // Request channel.
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire csc_pkg::csc_req_t in_data_i,
  // Result channel.
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output csc_pkg::csc_rsp_t   out_data_o,
  // Configuration channel: max_usage.
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire [2:0]           cfg_data_i
);

  import csc_pkg::*;

  // Slot index width and the last slot, used for wrapping the scan and hand.
  localparam int unsigned IdxWidth = $clog2(ENTRIES);
  localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(ENTRIES - 1);

  csc_state_e state_q, state_d;

  // Accepted request, held for the whole operation.
  csc_req_t req_q;

  // Usage ceiling register.
  logic [CountWidth-1:0] max_usage_q;

  // Key and value stores: one write port, one registered read port.
  logic [KeyWidth-1:0]   slot_keys   [ENTRIES];
  logic [ValueWidth-1:0] slot_values [ENTRIES];

  // Usage counts and valid bits live in flops so reset clears them at once.
  logic [CountWidth-1:0] cnt_q   [ENTRIES];
  logic [ENTRIES-1:0]    valid_q;

  logic [IdxWidth-1:0] hand_q;
  logic [IdxWidth-1:0] scan_idx_q;

  // Compare stage of the scan: the slot read last cycle and whether it counts.
  logic [IdxWidth-1:0]   cmp_idx_q;
  logic                  cmp_vld_q;
  logic [KeyWidth-1:0]   key_rd_q;
  logic [ValueWidth-1:0] val_rd_q;

  csc_rsp_t res_q;
  csc_rsp_t out_q;
  logic     out_valid_q;

  // Control produced by the output decoder.
  logic                  scan_en;
  logic                  match;
  logic [IdxWidth-1:0]   sel_idx;
  logic [CountWidth-1:0] sel_cnt;
  logic                  sel_valid;
  logic                  sel_busy;
  logic [CountWidth-1:0] ceil_cnt;
  logic                  cnt_we;
  logic [CountWidth-1:0] cnt_wdata;
  logic                  valid_set;
  logic                  key_we;
  logic                  val_we;
  logic [IdxWidth-1:0]   wr_idx;
  logic                  res_we;
  csc_rsp_t              res_d;
  logic                  hand_we;
  logic [IdxWidth-1:0]   hand_d;
  logic                  out_load;

  function automatic logic [IdxWidth-1:0] next_idx(input logic [IdxWidth-1:0] idx);
    next_idx = (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  // A hit is the first valid slot in index order whose key equals the request.
  assign match = cmp_vld_q && (key_rd_q == req_q.key);

  // During the sweep the count port follows the hand; otherwise the compared slot.
  assign sel_idx   = (state_q == ST_SWEEP) ? hand_q : cmp_idx_q;
  assign sel_cnt   = cnt_q[sel_idx];
  assign sel_valid = valid_q[sel_idx];
  assign sel_busy  = sel_valid && (sel_cnt != '0);

  // A ceiling of zero behaves as one.
  assign ceil_cnt = (max_usage_q == '0) ? CountWidth'(1) : max_usage_q;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_d = ST_RESP;
        end else if (scan_idx_q == LastIdx) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        if (match || (req_q.kind == KIND_GET)) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (!sel_busy) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output decoder: handshake and datapath control for the current state.
  always_comb begin
    in_stall_o = 1'b1;
    scan_en    = 1'b0;
    cnt_we     = 1'b0;
    cnt_wdata  = sel_cnt;
    valid_set  = 1'b0;
    key_we     = 1'b0;
    val_we     = 1'b0;
    wr_idx     = cmp_idx_q;
    res_we     = 1'b0;
    res_d      = '0;
    hand_we    = 1'b0;
    hand_d     = next_idx(hand_q);
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_SCAN, ST_LAST: begin
        scan_en = (state_q == ST_SCAN);
        if (match) begin
          // Raise the count up to the ceiling; a count above it is left alone.
          cnt_we          = (sel_cnt < ceil_cnt);
          cnt_wdata       = sel_cnt + 1'b1;
          val_we          = (req_q.kind == KIND_PUT);
          res_we          = 1'b1;
          res_d.hit       = 1'b1;
          res_d.read_value = (req_q.kind == KIND_GET) ? val_rd_q : '0;
          res_d.slot      = SlotWidth'(cmp_idx_q);
        end else if (state_q == ST_LAST) begin
          // A get miss reports all zeros.
          res_we = (req_q.kind == KIND_GET);
        end
      end
      ST_SWEEP: begin
        wr_idx  = hand_q;
        cnt_we  = 1'b1;
        hand_we = 1'b1;
        if (sel_busy) begin
          cnt_wdata = sel_cnt - 1'b1;
        end else begin
          cnt_wdata  = CountWidth'(1);
          valid_set  = 1'b1;
          key_we     = 1'b1;
          val_we     = 1'b1;
          res_we     = 1'b1;
          res_d.slot = SlotWidth'(hand_q);
        end
      end
      ST_RESP: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      max_usage_q <= CountWidth'(5);
      hand_q      <= '0;
      scan_idx_q  <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_usage_q <= cfg_data_i;
      end
      if (hand_we) begin
        hand_q <= hand_d;
      end
      if (state_q == ST_IDLE) begin
        scan_idx_q <= '0;
      end else if (scan_en) begin
        scan_idx_q <= next_idx(scan_idx_q);
      end
      cmp_vld_q <= scan_en && valid_q[scan_idx_q];
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Usage counts and valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        cnt_q[i] <= '0;
      end
      valid_q <= '0;
    end else begin
      if (cnt_we) begin
        cnt_q[sel_idx] <= cnt_wdata;
      end
      if (valid_set) begin
        valid_q[wr_idx] <= 1'b1;
      end
    end
  end

  // Key and value stores.
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      slot_keys[wr_idx] <= req_q.key;
    end
    if (val_we) begin
      slot_values[wr_idx] <= req_q.new_value;
    end
  end

  always_ff @(posedge clk_i) begin
    key_rd_q <= slot_keys[scan_idx_q];
    val_rd_q <= slot_values[scan_idx_q];
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      req_q <= in_data_i;
    end
    cmp_idx_q <= scan_idx_q;
    if (res_we) begin
      res_q <= res_d;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  // The register may be written at any time the block is idle.
  assign cfg_ready_o = (state_q == ST_IDLE);

endmodule

`default_nettype wire

FILE: src/csc_checker.sv
// ----------------------------------------------------------------------------
// csc_checker
// Port-level checks for the clock-sweep cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_stall_o,
  input wire                out_valid_o,
  input wire                out_stall_i,
  input wire csc_pkg::csc_rsp_t out_data_o
);

  import csc_pkg::*;

  // A stalled result transfer keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A miss never returns a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.read_value == '0)
    else $error("miss with nonzero read_value");

  // After a request transfer the block is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while busy");

  // A result only appears while a request was being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in progress");

endmodule

bind clock_sweep_cache csc_checker u_csc_checker (.*);

`default_nettype wire

FILE: tb/csc_tb_pkg.sv
// ----------------------------------------------------------------------------
// csc_tb_pkg
// Scoreboard for the clock-sweep cache. It keeps its own copy of the slot
// table and predicts the result of every request that the block accepts.
// ----------------------------------------------------------------------------
package csc_tb_pkg;

  import csc_pkg::*;

  localparam int unsigned SlotCount = 16;

  class cache_scoreboard;

    logic signed [KeyWidth-1:0]   slot_key   [SlotCount];
    logic signed [ValueWidth-1:0] slot_value [SlotCount];
    logic [CountWidth-1:0]        slot_usage [SlotCount];
    bit                           slot_used  [SlotCount];
    int unsigned                  hand;
    logic [2:0]                   usage_ceiling;
    csc_rsp_t                     expected_rsp_q[$];
    int unsigned                  mismatches;
    int unsigned                  responses_seen;
    int unsigned                  hits_seen;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i]  = 1'b0;
        slot_usage[i] = '0;
      end
      hand           = 0;
      usage_ceiling  = 3'd5;
      mismatches     = 0;
      responses_seen = 0;
      hits_seen      = 0;
    endfunction

    function void set_ceiling(logic [2:0] value);
      usage_ceiling = value;
    endfunction

    function int unsigned outstanding();
      return expected_rsp_q.size();
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) begin
        $display("MISMATCH at %0t: %s", $realtime, msg);
      end
    endtask

    // A ceiling of zero behaves as one; a count already above the ceiling
    // is left alone.
    function void raise_usage(int unsigned s);
      logic [2:0] top;
      top = (usage_ceiling == 3'd0) ? 3'd1 : usage_ceiling;
      if (slot_usage[s] < top) begin
        slot_usage[s] = slot_usage[s] + 1'b1;
      end
    endfunction

    function csc_rsp_t access_cache(csc_req_t req);
      csc_rsp_t    rsp;
      int          found;
      int unsigned h;
      rsp   = '0;
      found = -1;
      // Scan downward so that the lowest matching slot wins.
      for (int i = SlotCount - 1; i >= 0; i--) begin
        if (slot_used[i] && slot_key[i] == req.key) begin
          found = i;
        end
      end
      if (found >= 0) begin
        rsp.hit  = 1'b1;
        rsp.slot = SlotWidth'(found);
        if (req.kind == KIND_GET) begin
          rsp.read_value = slot_value[found];
        end else begin
          slot_value[found] = req.new_value;
        end
        raise_usage(found);
      end else if (req.kind == KIND_PUT) begin
        h = hand;
        while (slot_used[h] && slot_usage[h] != '0) begin
          slot_usage[h] = slot_usage[h] - 1'b1;
          h = (h + 1) % SlotCount;
        end
        slot_key[h]   = req.key;
        slot_value[h] = req.new_value;
        slot_usage[h] = 3'd1;
        slot_used[h]  = 1'b1;
        rsp.slot      = SlotWidth'(h);
        hand          = (h + 1) % SlotCount;
      end
      return rsp;
    endfunction

    function void note_request(csc_req_t req);
      expected_rsp_q.push_back(access_cache(req));
    endfunction

    task check_response(csc_rsp_t got);
      csc_rsp_t want;
      responses_seen++;
      if (got.hit) begin
        hits_seen++;
      end
      if (expected_rsp_q.size() == 0) begin
        report($sformatf("result with nothing expected: hit %0b value %h slot %0d",
                         got.hit, got.read_value, got.slot));
        return;
      end
      want = expected_rsp_q.pop_front();
      if (got.hit !== want.hit) begin
        report($sformatf("hit %0b, expected %0b", got.hit, want.hit));
      end
      if (got.read_value !== want.read_value) begin
        report($sformatf("read_value %h, expected %h", got.read_value, want.read_value));
      end
      if (got.slot !== want.slot) begin
        report($sformatf("slot %0d, expected %0d", got.slot, want.slot));
      end
    endtask

  endclass

endpackage

FILE: tb/tb_clock_sweep_cache.sv
// ----------------------------------------------------------------------------
// tb_clock_sweep_cache
// Self-checking testbench for the clock-sweep key-value cache. A directed
// opening exercises extreme keys and values, hits, misses, updates and count
// saturation; then random get/put traffic over small key pools forces table
// fills, sweeps and evictions under several usage ceilings and handshake
// patterns, while a scoreboard predicts and checks every result.
// ----------------------------------------------------------------------------
module tb_clock_sweep_cache;

  timeunit 1ns;
  timeprecision 1ps;

  import csc_pkg::*;
  import csc_tb_pkg::*;

  localparam int unsigned ClkPeriod = 12;
  // The slowest item is a put miss whose sweep circles the table just over
  // seven times. Even with heavy stalls the run stays far below this bound.
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned PoolSize   = 32;
  localparam int unsigned PhaseItems = 230;

  localparam logic signed [KeyWidth-1:0] KeyMin = 32'h8000_0000;
  localparam logic signed [KeyWidth-1:0] KeyMax = 32'h7fff_ffff;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  csc_req_t in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  csc_rsp_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [2:0] cfg_data = '0;

  // Handshake pressure for the current phase, in percent.
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;

  int unsigned requests_sent    = 0;
  int unsigned ceilings_written = 0;
  int unsigned cycle_count      = 0;

  logic signed [KeyWidth-1:0] key_pool [PoolSize];

  cache_scoreboard sb;

  always #(ClkPeriod / 2) clk = ~clk;

  clock_sweep_cache #(
    .ENTRIES(SlotCount)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  // The receiver stalls at random according to the phase. The stall is
  // updated at the edge, so the monitor below sees the value that was in
  // force when the edge arrived.
  always @(posedge clk) begin
    out_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
  end

  // A result transfer happens at an edge where valid is high and stall low.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_response(out_data);
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.",
             cycle_count, sb.outstanding());
    $display("clock_sweep_cache verification failed");
    $finish;
  end

  function automatic csc_req_t make_request(csc_kind_e kind,
                                            logic signed [KeyWidth-1:0] key,
                                            logic signed [ValueWidth-1:0] value);
    csc_req_t r;
    r.kind      = kind;
    r.key       = key;
    r.new_value = value;
    return r;
  endfunction

  // Most keys come from a small pool so that gets hit and puts evict; the
  // rest are fully random and almost always miss.
  function automatic csc_req_t random_request(int unsigned pool_span, int unsigned put_pct);
    csc_req_t r;
    r.kind = ($urandom_range(99) < put_pct) ? KIND_PUT : KIND_GET;
    if ($urandom_range(9) < 8) begin
      r.key = key_pool[$urandom_range(pool_span - 1)];
    end else begin
      r.key = $urandom();
    end
    r.new_value = $urandom();
    return r;
  endfunction

  // Each call starts at a clock edge and returns at the edge of the
  // transfer, leaving valid high. The next call either lowers valid for a
  // gap or presents new data, so valid gets one assignment per edge.
  task automatic send_request(csc_req_t req);
    int unsigned gap;
    gap = 0;
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
    requests_sent++;
  endtask

  // Every request yields one result, so an empty scoreboard means the block
  // is idle.
  task automatic drain();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_ceiling(logic [2:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_ceiling(value);
    ceilings_written++;
  endtask

  // A phase sets the ceiling, the handshake pressure and the key pool,
  // streams random traffic, then pauses until every result is back.
  task automatic run_phase(logic [2:0] ceiling, int unsigned idle_pct,
                           int unsigned stall_pct, int unsigned pool_span,
                           int unsigned put_pct);
    write_ceiling(ceiling);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (PhaseItems) send_request(random_request(pool_span, put_pct));
    in_valid <= 1'b0;
    drain();
  endtask

  initial begin
    sb = new();
    foreach (key_pool[i]) begin
      key_pool[i] = $urandom();
    end
    // The extreme keys stay in every pool so they keep being hit and evicted.
    key_pool[0] = KeyMin;
    key_pool[1] = KeyMax;
    key_pool[2] = '0;
    key_pool[3] = '1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening, at the reset ceiling of five. A get on the empty
    // table misses, then the extreme keys go in with extreme values.
    send_request(make_request(KIND_GET, '0, '1));
    send_request(make_request(KIND_PUT, KeyMin, KeyMax));
    send_request(make_request(KIND_PUT, KeyMax, KeyMin));
    send_request(make_request(KIND_PUT, '0, '0));
    send_request(make_request(KIND_PUT, '1, '1));
    send_request(make_request(KIND_GET, KeyMin, '0));
    send_request(make_request(KIND_GET, KeyMax, '0));
    send_request(make_request(KIND_GET, '0, '1));
    send_request(make_request(KIND_GET, '1, '0));
    // A put on a present key updates in place and leaves the hand alone.
    send_request(make_request(KIND_PUT, KeyMax, 32'h5a5a_a5a5));
    send_request(make_request(KIND_GET, KeyMax, '0));
    // Repeated hits drive one count into saturation at the ceiling.
    repeat (6) send_request(make_request(KIND_GET, KeyMin, '0));
    send_request(make_request(KIND_GET, 32'sd1, '0));
    send_request(make_request(KIND_PUT, 32'sd1, 32'sd1));
    in_valid <= 1'b0;
    drain();

    // Random phases. High ceilings followed by low ones leave counts above
    // the new ceiling; a ceiling of zero must behave as one. Pools larger
    // than the table keep the sweep busy with evictions.
    run_phase(3'd7,  0,  0, 20, 50);
    run_phase(3'd1, 51,  0, 24, 50);
    run_phase(3'd0,  0, 51, 12, 40);
    run_phase(3'd3, 19, 19, 32, 60);
    run_phase(3'd6, 51, 51, 18, 50);
    run_phase(3'd2,  0,  0, 28, 50);
    run_phase(3'd4, 19, 19, 16, 50);
    run_phase(3'd5, 51,  0, 32, 50);

    repeat (20) @(posedge clk);
    if (sb.outstanding() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.outstanding()));
    end

    $display("Sent %0d get/put requests over %0d ceiling settings; %0d results checked, %0d hits.",
             requests_sent, ceilings_written, sb.responses_seen, sb.hits_seen);
    $display("Traffic ran with and without sender gaps and result back-pressure; %0d mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("clock_sweep_cache verification clean");
    end else begin
      $display("clock_sweep_cache verification failed");
    end
    $finish;
  end

endmodule
